/* sv/key_matrix_change_detector_core_assert.svh */
// assertion macros used by the key matrix change detector controller
`ifndef KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, masked while reset is asserted
`define KMCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define KMCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KMCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMCD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/kmcd_pkg.sv */
package kmcd_pkg;

	// field widths
	localparam int COL_W       = 2;
	localparam int ROW_LVL_W   = 8;
	localparam int KEY_INDEX_W = 5;
	localparam int KEY_COUNT_W = 6;
	// internal key number width, covers column 3 with sixteen rows
	localparam int KEY_W       = 6;
	// rows beyond this are ignored
	localparam int MAX_ROWS    = 8;

	localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 6'd25;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pop;
	} kmcd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic load_hit;
		logic last;
	} kmcd_stat_t;

endpackage

/* sv/key_matrix_change_detector_core.sv */
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+----------------------------------------
// s        | in  | s_tvalid/s_tready  | s_tdata: column, row_levels
// m        | out | m_tvalid/m_tready  | m_tdata: key_index; tuser is_press; tlast
// cfg      | in  | cfg_we             | cfg_wdata: key_count
//
// a sample is accepted while idle; a sample that changes n wired keys then
// holds the input off until its n event beats are taken, one beat per cycle
// built from the held sample as the pending-row scan drains lowest row first
// with m_tready low the current beat holds and the scan waits
// reset clears the pressed map and restores key_count to 25 at once
module key_matrix_change_detector_core #(
	parameter int ROWS = 8,
	parameter int COLS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // [1:0] column, [9:2] row_levels
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // [4:0] key_index
	output logic                             m_tuser,   // [0] is_press
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [kmcd_pkg::KEY_COUNT_W-1:0] cfg_wdata
);
	import kmcd_pkg::*;

	kmcd_cmd_t               cmd;
	kmcd_stat_t              st;
	logic [KEY_INDEX_W-1:0]  key_index;
	logic                    is_press;

	kmcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.st        (st)
	);

	kmcd_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.col        (s_tdata[COL_W-1:0]),
		.row_levels (s_tdata[COL_W+ROW_LVL_W-1:COL_W]),
		.key_index  (key_index),
		.is_press   (is_press)
	);

	// output beat packing
	assign m_tdata = {{(8-KEY_INDEX_W){1'b0}}, key_index};
	assign m_tuser = is_press;
	assign m_tlast = st.last;

endmodule

/* sv/kmcd_dp.sv */
module kmcd_dp #(
	parameter int ROWS = 8,
	parameter int COLS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kmcd_pkg::kmcd_cmd_t               cmd,
	output kmcd_pkg::kmcd_stat_t              st,
	input  logic                              cfg_we,
	input  logic [kmcd_pkg::KEY_COUNT_W-1:0]  cfg_wdata,
	input  logic [kmcd_pkg::COL_W-1:0]        col,
	input  logic [kmcd_pkg::ROW_LVL_W-1:0]    row_levels,
	output logic [kmcd_pkg::KEY_INDEX_W-1:0]  key_index,
	output logic                              is_press
);
	import kmcd_pkg::*;

	localparam int NR  = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
	localparam int RW  = (NR > 1) ? $clog2(NR) : 1;
	localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;
	// compare width holds both the column field and the column count
	localparam int CLW = ($clog2(COLS + 1) > COL_W) ? $clog2(COLS + 1) : COL_W;

	logic [KEY_COUNT_W-1:0] key_count_q;
	logic [NR-1:0]          map_q [COLS];
	logic [NR-1:0]          pending_q;
	logic [NR-1:0]          now_q;
	logic [COL_W-1:0]       col_q;

	logic [NR-1:0]          now;
	logic [NR-1:0]          old;
	logic [NR-1:0]          wired;
	logic [NR-1:0]          hit;
	logic                   col_ok;
	logic [NR-1:0]          pending_rest;
	logic [RW-1:0]          low_idx;
	logic                   found;
	logic [KEY_W-1:0]       key_out;

	// new pressed state and per-row event mask for the incoming sample
	assign col_ok = (CLW'(col) < CLW'(COLS));
	assign old    = map_q[CIW'(col)];

	always_comb begin
		for (int r = 0; r < NR; r++) begin
			now[r]   = ~row_levels[r];
			wired[r] = ((KEY_W'(col) * KEY_W'(ROWS) + KEY_W'(r)) < KEY_W'(key_count_q));
		end
	end

	assign hit = col_ok ? ((old ^ now) & wired) : '0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KEY_COUNT_RESET;
		end else if (cfg_we) begin
			key_count_q <= cfg_wdata;
		end
	end

	// pressed map, one row vector per column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COLS; c++) begin
				map_q[c] <= '0;
			end
		end else if (cmd.load && col_ok) begin
			map_q[CIW'(col)] <= now;
		end
	end

	// pending event rows, drained lowest first
	assign pending_rest = pending_q & (pending_q - NR'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd.load) begin
			pending_q <= hit;
		end else if (cmd.pop) begin
			pending_q <= pending_rest;
		end
	end

	// sample payload kept for event building
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now;
			col_q <= col;
		end
	end

	// lowest pending row
	always_comb begin
		low_idx = '0;
		found   = 1'b0;
		for (int i = 0; i < NR; i++) begin
			if (!found && pending_q[i]) begin
				low_idx = RW'(i);
				found   = 1'b1;
			end
		end
	end

	// event fields
	assign key_out   = KEY_W'(col_q) * KEY_W'(ROWS) + KEY_W'(low_idx);
	assign key_index = key_out[KEY_INDEX_W-1:0];
	assign is_press  = now_q[low_idx];

	assign st.load_hit = (hit != '0);
	assign st.last     = (pending_rest == '0);

endmodule

/* sv/kmcd_ctrl.sv */
module kmcd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output kmcd_pkg::kmcd_cmd_t   cmd,
	input  kmcd_pkg::kmcd_stat_t  st
);
	import kmcd_pkg::*;
	`include "key_matrix_change_detector_core_assert.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.pop   = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && st.load_hit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.pop && st.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// checks
	`KMCD_ASSERT(a_sides_exclusive, clk, arst_n, !(in_ready && out_valid), "ready while emitting")
	`KMCD_ASSERT(a_hit_emits, clk, arst_n, cmd.load && st.load_hit |=> out_valid, "hit without event")
	`KMCD_ASSERT(a_miss_idle, clk, arst_n, cmd.load && !st.load_hit |=> in_ready, "idle sample stalled")
	`KMCD_ASSERT(a_last_frees, clk, arst_n, cmd.pop && st.last |=> in_ready, "no return after last beat")
	`KMCD_ASSERT(a_more_events, clk, arst_n, cmd.pop && !st.last |=> out_valid, "events dropped")

endmodule

/* tb/key_matrix_change_detector_core_tb.sv */
`timescale 1ns / 1ps

module key_matrix_change_detector_core_tb;

	import kmcd_pkg::*;

	localparam int ROWS        = 8;
	localparam int COLS        = 4;
	localparam int SETTLE      = 12;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	// column in the low bits, row levels above it
	typedef struct packed {
		logic [ROW_LVL_W-1:0] levels;
		logic [COL_W-1:0]     col;
	} scan_sample_t;

	typedef struct packed {
		logic [KEY_INDEX_W-1:0] key;
		logic                   press;
		logic                   last;
	} key_event_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [7:0]             m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [KEY_COUNT_W-1:0] cfg_wdata = '0;

	// predictor state: pressed keys per column and the wired key count
	logic [ROWS-1:0]        held_keys [COLS];
	logic [KEY_COUNT_W-1:0] key_limit;

	scan_sample_t scan_q [$];
	key_event_t   key_event_q [$];

	int unsigned n_queued;
	int unsigned n_taken;
	int unsigned err_cnt;
	int unsigned cycle_cnt;
	int unsigned src_gap;
	int unsigned sink_gap;
	int unsigned hold_cnt;
	bit          idle_en;
	bit          long_hold;

	// stimulus generator memory of the last levels sent per column
	logic [ROW_LVL_W-1:0] gen_levels [COLS];
	logic [COL_W-1:0]     gen_col;

	key_matrix_change_detector_core #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// work out the events one sample causes and update the pressed map
	function automatic void predict_key_events(input scan_sample_t smp);
		logic [ROWS-1:0] now_held;
		key_event_t      evs [$];
		key_event_t      ev;
		int unsigned     key;
		now_held = ~smp.levels[ROWS-1:0];
		for (int r = 0; r < ROWS; r++) begin
			key = smp.col * ROWS + r;
			if (now_held[r] != held_keys[smp.col][r] && key < key_limit) begin
				ev.key   = key[KEY_INDEX_W-1:0];
				ev.press = now_held[r];
				ev.last  = 1'b0;
				evs.push_back(ev);
			end
		end
		if (evs.size() != 0)
			evs[evs.size()-1].last = 1'b1;
		foreach (evs[i])
			key_event_q.push_back(evs[i]);
		held_keys[smp.col] = now_held;
	endfunction

	task automatic push_sample(input int col, input int levels);
		scan_sample_t smp;
		smp.col    = col[COL_W-1:0];
		smp.levels = levels[ROW_LVL_W-1:0];
		gen_levels[smp.col] = smp.levels;
		scan_q.push_back(smp);
		n_queued++;
	endtask

	// wait until every sample is taken and every event has come out
	task automatic drain();
		while (n_taken != n_queued || key_event_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_key_count(input int value);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[KEY_COUNT_W-1:0];
		key_limit = value[KEY_COUNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random scan traffic: mostly column-ordered scans with few changed rows
	task automatic run_random(input int n_items, input bit hold_off);
		int col;
		int levels;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 9) < 7)
				gen_col = gen_col + 1'b1;
			else
				gen_col = $urandom_range(0, COLS - 1);
			col  = gen_col;
			pick = $urandom_range(0, 9);
			if (pick < 4)
				levels = $urandom_range(0, 255);
			else if (pick < 8)
				levels = gen_levels[gen_col] ^ (1 << $urandom_range(0, 7))
					^ (($urandom_range(0, 1)) << $urandom_range(0, 7));
			else
				levels = gen_levels[gen_col];
			push_sample(col, levels);
		end
		if (hold_off)
			long_hold = 1'b1;
		drain();
	endtask

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_key_events(scan_sample_t'(s_tdata[COL_W+ROW_LVL_W-1:0]));
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap == 0 && idle_en && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 14);
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (scan_q.size() != 0) begin
					s_tdata  <= {6'b0, scan_q.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (long_hold) begin
			if (hold_cnt >= LONG_HOLD) begin
				long_hold = 1'b0;
				hold_cnt  = 0;
			end else begin
				hold_cnt++;
			end
		end
	end

	// receiver ready with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (sink_gap > 0)
				sink_gap--;
			else if (idle_en && $urandom_range(0, 7) == 0)
				sink_gap = $urandom_range(1, 14);
			m_tready <= !(long_hold || sink_gap > 0);
		end
	end

	// event checker
	always @(posedge clk) begin
		key_event_t exp_ev;
		if (arst_n && m_tvalid && m_tready) begin
			if (key_event_q.size() == 0) begin
				if (err_cnt < MAX_REPORTS)
					$display("unexpected event beat: tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast);
				err_cnt++;
			end else begin
				exp_ev = key_event_q.pop_front();
				if (m_tdata !== {3'b0, exp_ev.key} || m_tuser !== exp_ev.press
						|| m_tlast !== exp_ev.last) begin
					if (err_cnt < MAX_REPORTS)
						$display("event mismatch: exp key=%0d press=%b last=%b, got tdata=%h tuser=%b tlast=%b",
							exp_ev.key, exp_ev.press, exp_ev.last, m_tdata, m_tuser, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		foreach (held_keys[c])
			held_keys[c] = '0;
		foreach (gen_levels[c])
			gen_levels[c] = 8'hFF;
		key_limit = KEY_COUNT_RESET;
		gen_col   = '0;
		idle_en   = 1'b1;
		long_hold = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key count: no change, full press and release, toggles
		push_sample(0, 8'hFF);
		push_sample(0, 8'h00);
		push_sample(0, 8'h00);
		push_sample(0, 8'hFF);
		push_sample(1, 8'hAA);
		push_sample(1, 8'h55);
		push_sample(1, 8'hFF);
		// column 3: only row 0 is wired, unwired-only change gives nothing
		push_sample(3, 8'h00);
		push_sample(3, 8'h01);
		push_sample(3, 8'hFF);
		push_sample(2, 8'h7F);
		push_sample(2, 8'hFF);

		// every position wired
		set_key_count(32);
		push_sample(3, 8'h00);
		push_sample(3, 8'hFF);
		// zero disables all events but the map still follows
		set_key_count(0);
		push_sample(0, 8'h00);
		push_sample(2, 8'h0F);
		set_key_count(63);
		push_sample(0, 8'hFF);
		push_sample(2, 8'hFF);
		push_sample(3, 8'h00);
		set_key_count(1);
		push_sample(0, 8'h00);
		push_sample(3, 8'hFF);
		push_sample(0, 8'hFF);

		// random phases across several key counts
		set_key_count(32);
		run_random(40, 1'b0);
		set_key_count(0);
		run_random(35, 1'b0);
		set_key_count(63);
		run_random(40, 1'b1);
		set_key_count($urandom_range(1, 31));
		run_random(40, 1'b0);
		set_key_count(8);
		run_random(40, 1'b0);
		set_key_count(32);
		idle_en = 1'b0;
		run_random(63, 1'b0);

		if (err_cnt == 0 && key_event_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
